>>> hdl/flcpi_pkg.sv
// ----------------------------------------------------------------------------
// flcpi_pkg
// Types, constants and fixed-point helpers for the PI flight control law.
// ----------------------------------------------------------------------------
package flcpi_pkg;

  localparam int SIG_W      = 32;
  localparam int ACC_W      = 64;
  localparam int SIG_FRAC   = 16;
  localparam int ACC_FRAC   = 40;
  localparam int GAIN_FRAC  = 32;
  localparam int GAIN_SHIFT = GAIN_FRAC + SIG_FRAC - ACC_FRAC;
  localparam int DT_SHIFT   = 32;
  localparam int ACC_SHIFT  = ACC_FRAC - SIG_FRAC;
  localparam int OPB_W      = SIG_W + 1;
  localparam int PP_W       = 2 * OPB_W;
  localparam int FULL_W     = PP_W + 32;
  localparam int ADDR_W     = 5;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_MONITOR_ROLE   = 3'd0;
  localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd1;
  localparam logic [2:0] REG_AIRSPEED_EQ    = 3'd2;
  localparam logic [2:0] REG_ELEVATOR_TRIM  = 3'd3;
  localparam logic [2:0] REG_THROTTLE_TRIM  = 3'd4;
  localparam logic [2:0] REG_ALTITUDE_BAND  = 3'd5;
  localparam logic [2:0] REG_MISMATCH_THR   = 3'd6;

  localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd21474836;
  localparam logic [30:0] ALTITUDE_BAND_RST = 31'd3276800;
  localparam logic [30:0] MISMATCH_THR_RST  = 31'd66;

  // Gains, signed with 32 fraction bits
  localparam logic signed [63:0] KP_H      = 64'sd435530300;
  localparam logic signed [63:0] KI_H      = 64'sd20739538;
  localparam logic signed [63:0] KI_VA     = 64'sd213900584;
  localparam logic signed [63:0] K1_VA     = -64'sd2090846277;
  localparam logic signed [63:0] K1_VZ     = -64'sd333302757;
  localparam logic signed [63:0] K1_Q      = 64'sd93168077174;
  localparam logic signed [63:0] KI_VZ     = 64'sd2694417;
  localparam logic signed [63:0] K2_VZ     = -64'sd13970827;
  localparam logic signed [63:0] K2_Q      = 64'sd1615214565;
  localparam logic signed [63:0] K2_AZ     = -64'sd6729816;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK,
    ST_HKP, ST_HRS, ST_HVZ, ST_HKI, ST_HDT, ST_HIA,
    ST_T1, ST_T1A, ST_T2, ST_T2A, ST_T3, ST_T3A, ST_TO, ST_TI, ST_TD, ST_TIA,
    ST_E1, ST_E1A, ST_E2, ST_E2A, ST_E3, ST_E3A, ST_EO, ST_EI, ST_ED, ST_EIA,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_BAND_OUT, OP_VZ_CMD, OP_RESEED, OP_HOLD_VZ, OP_HOLD_INT,
    OP_ACC_THR, OP_ACC_ELEV, OP_ACC_ADD, OP_THR_OUT, OP_THR_INT, OP_ELEV_OUT,
    OP_ELEV_INT, OP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    G_KP_H, G_KI_H, G_KI_VA, G_K1_VA, G_K1_VZ, G_K1_Q,
    G_KI_VZ, G_K2_VZ, G_K2_Q, G_K2_AZ
  } gain_sel_t;

  typedef enum logic [2:0] {
    B_ALT_ERR, B_VA_TRIM, B_VZ, B_Q, B_AZ, B_VA_ERR, B_VZ_ERR, B_DT
  } opb_sel_t;

  typedef struct packed {
    dp_op_t    op;
    logic      mul_go;
    gain_sel_t gain_sel;
    opb_sel_t  opb_sel;
    logic      a_prod;   // multiply the last product by dt instead of a gain
  } cmd_t;

  typedef struct packed {
    logic mode_invalid;
    logic mode_hold;
    logic out_band;
    logic mul_done;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic        monitor_role;
    logic [31:0] sample_period;
    logic [31:0] airspeed_eq;
    logic [30:0] altitude_band;
    logic [30:0] mismatch_thr;
  } cfg_t;

  typedef struct packed {
    logic        elev_load;
    logic        thr_load;
    logic [31:0] value;
  } trim_load_t;

  function automatic logic signed [63:0] gain_value(gain_sel_t sel);
    logic signed [63:0] k;
    case (sel)
      G_KP_H:  k = KP_H;
      G_KI_H:  k = KI_H;
      G_KI_VA: k = KI_VA;
      G_K1_VA: k = K1_VA;
      G_K1_VZ: k = K1_VZ;
      G_K1_Q:  k = K1_Q;
      G_KI_VZ: k = KI_VZ;
      G_K2_VZ: k = K2_VZ;
      G_K2_Q:  k = K2_Q;
      G_K2_AZ: k = K2_AZ;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                     logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sub(logic signed [ACC_W-1:0] a,
                                                     logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) - (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] to_acc(logic signed [SIG_W-1:0] s);
    return ACC_W'(s) <<< ACC_SHIFT;
  endfunction

  // floor to signal format, then clamp
  function automatic logic signed [SIG_W-1:0] to_sig(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] sh;
    sh = a >>> ACC_SHIFT;
    if (sh[ACC_W-1:SIG_W-1] != {(ACC_W-SIG_W+1){sh[ACC_W-1]}})
      return sh[ACC_W-1] ? SIG_MIN : SIG_MAX;
    return sh[SIG_W-1:0];
  endfunction

  function automatic logic signed [SIG_W-1:0] neg_sat(logic signed [SIG_W-1:0] s);
    if (s == SIG_MIN) return SIG_MAX;
    return -s;
  endfunction

endpackage

>>> hdl/flcpi_if.sv
// ----------------------------------------------------------------------------
// flcpi_in_if / flcpi_out_if
// Sample and command channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface flcpi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] altitude_meas;
  logic [31:0] vspeed_meas;
  logic [31:0] airspeed_meas;
  logic [31:0] pitch_rate_meas;
  logic [31:0] vaccel_meas;
  logic [31:0] altitude_set;
  logic [31:0] vspeed_set;
  logic [31:0] airspeed_set;
  logic [31:0] partner_elevator;
  logic [31:0] partner_throttle;
  logic        other_in_law;

  modport source (output valid, mode, altitude_meas, vspeed_meas, airspeed_meas,
                  pitch_rate_meas, vaccel_meas, altitude_set, vspeed_set,
                  airspeed_set, partner_elevator, partner_throttle, other_in_law,
                  input ready);
  modport sink (input valid, mode, altitude_meas, vspeed_meas, airspeed_meas,
                pitch_rate_meas, vaccel_meas, altitude_set, vspeed_set,
                airspeed_set, partner_elevator, partner_throttle, other_in_law,
                output ready);
endinterface

interface flcpi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] elevator_cmd;
  logic [31:0] throttle_cmd;
  logic        relay_elevator;
  logic        relay_throttle;
  logic        law_master;
  logic        status;

  modport source (output valid, elevator_cmd, throttle_cmd, relay_elevator,
                  relay_throttle, law_master, status, input ready);
  modport sink (input valid, elevator_cmd, throttle_cmd, relay_elevator,
                relay_throttle, law_master, status, output ready);
endinterface

>>> hdl/flcpi_ctrl.sv
// ----------------------------------------------------------------------------
// flcpi_ctrl
// Sequencer: steps the datapath through the control law, one product at a time.
// ----------------------------------------------------------------------------
module flcpi_ctrl
  import flcpi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.mul_go   = 1'b0;
    cmd.gain_sel = G_KP_H;
    cmd.opb_sel  = B_ALT_ERR;
    cmd.a_prod   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (stat.mode_invalid) begin
          state_nxt = ST_OUT;
        end else if (!stat.mode_hold) begin
          cmd.op    = OP_VZ_CMD;
          state_nxt = ST_T1;
        end else if (stat.out_band) begin
          cmd.op    = OP_BAND_OUT;
          state_nxt = ST_T1;
        end else begin
          state_nxt = ST_HKP;
        end
      end
      // altitude hold inside the band
      ST_HKP: begin
        cmd.mul_go = 1'b1; cmd.gain_sel = G_KP_H; cmd.opb_sel = B_ALT_ERR;
        if (stat.mul_done) state_nxt = ST_HRS;
      end
      ST_HRS: begin
        cmd.op = OP_RESEED; state_nxt = ST_HVZ;
      end
      ST_HVZ: begin
        cmd.op = OP_HOLD_VZ; state_nxt = ST_HKI;
      end
      ST_HKI: begin
        cmd.mul_go = 1'b1; cmd.gain_sel = G_KI_H; cmd.opb_sel = B_ALT_ERR;
        if (stat.mul_done) state_nxt = ST_HDT;
      end
      ST_HDT: begin
        cmd.mul_go = 1'b1; cmd.a_prod = 1'b1; cmd.opb_sel = B_DT;
        if (stat.mul_done) state_nxt = ST_HIA;
      end
      ST_HIA: begin
        cmd.op = OP_HOLD_INT; state_nxt = ST_T1;
      end
      // throttle law
      ST_T1: begin
        cmd.mul_go = 1'b1; cmd.gain_sel = G_K1_VA; cmd.opb_sel = B_VA_TRIM;
        if (stat.mul_done) state_nxt = ST_T1A;
      end
      ST_T1A: begin
        cmd.op = OP_ACC_THR; state_nxt = ST_T2;
      end
      ST_T2: begin
        cmd.mul_go = 1'b1; cmd.gain_sel = G_K1_VZ; cmd.opb_sel = B_VZ;
        if (stat.mul_done) state_nxt = ST_T2A;
      end
      ST_T2A: begin
        cmd.op = OP_ACC_ADD; state_nxt = ST_T3;
      end
      ST_T3: begin
        cmd.mul_go = 1'b1; cmd.gain_sel = G_K1_Q; cmd.opb_sel = B_Q;
        if (stat.mul_done) state_nxt = ST_T3A;
      end
      ST_T3A: begin
        cmd.op = OP_ACC_ADD; state_nxt = ST_TO;
      end
      ST_TO: begin
        cmd.op = OP_THR_OUT; state_nxt = ST_TI;
      end
      ST_TI: begin
        cmd.mul_go = 1'b1; cmd.gain_sel = G_KI_VA; cmd.opb_sel = B_VA_ERR;
        if (stat.mul_done) state_nxt = ST_TD;
      end
      ST_TD: begin
        cmd.mul_go = 1'b1; cmd.a_prod = 1'b1; cmd.opb_sel = B_DT;
        if (stat.mul_done) state_nxt = ST_TIA;
      end
      ST_TIA: begin
        cmd.op = OP_THR_INT; state_nxt = ST_E1;
      end
      // elevator law
      ST_E1: begin
        cmd.mul_go = 1'b1; cmd.gain_sel = G_K2_VZ; cmd.opb_sel = B_VZ;
        if (stat.mul_done) state_nxt = ST_E1A;
      end
      ST_E1A: begin
        cmd.op = OP_ACC_ELEV; state_nxt = ST_E2;
      end
      ST_E2: begin
        cmd.mul_go = 1'b1; cmd.gain_sel = G_K2_Q; cmd.opb_sel = B_Q;
        if (stat.mul_done) state_nxt = ST_E2A;
      end
      ST_E2A: begin
        cmd.op = OP_ACC_ADD; state_nxt = ST_E3;
      end
      ST_E3: begin
        cmd.mul_go = 1'b1; cmd.gain_sel = G_K2_AZ; cmd.opb_sel = B_AZ;
        if (stat.mul_done) state_nxt = ST_E3A;
      end
      ST_E3A: begin
        cmd.op = OP_ACC_ADD; state_nxt = ST_EO;
      end
      ST_EO: begin
        cmd.op = OP_ELEV_OUT; state_nxt = ST_EI;
      end
      ST_EI: begin
        cmd.mul_go = 1'b1; cmd.gain_sel = G_KI_VZ; cmd.opb_sel = B_VZ_ERR;
        if (stat.mul_done) state_nxt = ST_ED;
      end
      ST_ED: begin
        cmd.mul_go = 1'b1; cmd.a_prod = 1'b1; cmd.opb_sel = B_DT;
        if (stat.mul_done) state_nxt = ST_EIA;
      end
      ST_EIA: begin
        cmd.op = OP_ELEV_INT; state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.op    = OP_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/flcpi_dp.sv
// ----------------------------------------------------------------------------
// flcpi_dp
// Datapath: sample registers, law state, shared multiplier and output register.
// ----------------------------------------------------------------------------
module flcpi_dp
  import flcpi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  flcpi_in_if.sink     in_ch,
  flcpi_out_if.source  out_ch,
  input  cfg_t         cfg,
  input  trim_load_t   trim,
  input  cmd_t         cmd,
  output status_t      stat
);

  // captured sample
  logic [1:0]               mode_r;
  logic signed [SIG_W-1:0]  h_f_r, vz_f_r, va_f_r, q_f_r, az_f_r;
  logic signed [SIG_W-1:0]  h_c_r, vz_c_r, va_c_r, pe_r, pt_r;
  logic                     other_r;

  // law state
  logic signed [ACC_W-1:0]  hold_int_r, elev_int_r, thr_int_r;
  logic                     reseed_r;
  logic signed [SIG_W-1:0]  last_vz_r;

  // working registers
  logic signed [SIG_W-1:0]  vz_r, elev_r, thr_r;
  logic signed [ACC_W-1:0]  acc_r, prod_r;
  logic [1:0]               phase_r;
  logic signed [PP_W-1:0]   pp_lo_r, pp_hi_r;

  // output register
  logic                     out_valid_r;
  logic [SIG_W-1:0]         out_elev_r, out_thr_r;
  logic                     out_re_r, out_rt_r, out_ml_r, out_status_r;

  logic signed [OPB_W-1:0]  alt_err, mul_b;
  logic signed [ACC_W-1:0]  mul_a, prod_nxt;
  logic signed [OPB_W-1:0]  a_lo, a_hi;
  logic signed [FULL_W-1:0] full, shifted;
  logic signed [OPB_W:0]    band_s, alt_s;
  logic signed [OPB_W:0]    d_elev, d_thr;
  logic [OPB_W:0]           abs_elev, abs_thr;
  logic                     re, rt;

  assign alt_err = OPB_W'(h_f_r) - OPB_W'(h_c_r);
  assign band_s  = $signed({3'b000, cfg.altitude_band});
  assign alt_s   = (OPB_W+1)'(alt_err);

  assign stat.mode_invalid = mode_r[1];
  assign stat.mode_hold    = (mode_r == 2'd0);
  assign stat.out_band     = (alt_s > band_s) || (alt_s < -band_s);
  assign stat.mul_done     = (phase_r == 2'd2);
  assign stat.out_free     = !out_valid_r || out_ch.ready;

  // multiplier operands
  assign mul_a = cmd.a_prod ? prod_r : gain_value(cmd.gain_sel);
  assign a_lo  = $signed({1'b0, mul_a[31:0]});
  assign a_hi  = $signed({mul_a[ACC_W-1], mul_a[ACC_W-1:32]});

  always_comb begin
    case (cmd.opb_sel)
      B_ALT_ERR: mul_b = alt_err;
      B_VA_TRIM: mul_b = OPB_W'(va_f_r) - OPB_W'($signed(cfg.airspeed_eq));
      B_VZ:      mul_b = OPB_W'(vz_f_r);
      B_Q:       mul_b = OPB_W'(q_f_r);
      B_AZ:      mul_b = OPB_W'(az_f_r);
      B_VA_ERR:  mul_b = OPB_W'(va_c_r) - OPB_W'(va_f_r);
      B_VZ_ERR:  mul_b = OPB_W'(vz_r) - OPB_W'(vz_f_r);
      B_DT:      mul_b = $signed({1'b0, cfg.sample_period});
      default:   mul_b = '0;
    endcase
  end

  // combine partial products, floor-shift, saturate
  assign full    = (FULL_W'(pp_hi_r) <<< 32) + FULL_W'(pp_lo_r);
  assign shifted = cmd.a_prod ? (full >>> DT_SHIFT) : (full >>> GAIN_SHIFT);
  always_comb begin
    if (shifted[FULL_W-1:ACC_W-1] != {(FULL_W-ACC_W+1){shifted[FULL_W-1]}})
      prod_nxt = shifted[FULL_W-1] ? ACC_MIN : ACC_MAX;
    else
      prod_nxt = shifted[ACC_W-1:0];
  end

  // monitor compare
  assign d_elev   = (OPB_W+1)'(elev_r) - (OPB_W+1)'(pe_r);
  assign d_thr    = (OPB_W+1)'(thr_r) - (OPB_W+1)'(pt_r);
  assign abs_elev = d_elev[OPB_W] ? unsigned'(-d_elev) : unsigned'(d_elev);
  assign abs_thr  = d_thr[OPB_W] ? unsigned'(-d_thr) : unsigned'(d_thr);
  assign re       = abs_elev >= (OPB_W+1)'(cfg.mismatch_thr);
  assign rt       = abs_thr >= (OPB_W+1)'(cfg.mismatch_thr);

  // control and law state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 2'd0;
      out_valid_r <= 1'b0;
      hold_int_r  <= '0;
      reseed_r    <= 1'b1;
      last_vz_r   <= '0;
      elev_int_r  <= '0;
      thr_int_r   <= '0;
    end else begin
      case (phase_r)
        2'd0:    if (cmd.mul_go) phase_r <= 2'd1;
        2'd1:    phase_r <= 2'd2;
        default: phase_r <= 2'd0;
      endcase
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (cmd.op == OP_FINISH) out_valid_r <= 1'b1;

      if (trim.elev_load) elev_int_r <= to_acc(trim.value);
      else if (cmd.op == OP_ELEV_INT) elev_int_r <= sat_add(elev_int_r, prod_r);
      if (trim.thr_load) thr_int_r <= to_acc(trim.value);
      else if (cmd.op == OP_THR_INT) thr_int_r <= sat_add(thr_int_r, prod_r);

      case (cmd.op)
        OP_BAND_OUT: begin
          reseed_r  <= 1'b1;
          last_vz_r <= alt_err[OPB_W-1] ? vz_c_r : neg_sat(vz_c_r);
        end
        OP_RESEED: begin
          if (reseed_r) begin
            hold_int_r <= sat_sub(to_acc(last_vz_r), prod_r);
            reseed_r   <= 1'b0;
          end
        end
        OP_HOLD_INT: hold_int_r <= sat_add(hold_int_r, prod_r);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (phase_r == 2'd0) pp_lo_r <= a_lo * mul_b;
    if (phase_r == 2'd1) pp_hi_r <= a_hi * mul_b;
    if (phase_r == 2'd2) prod_r  <= prod_nxt;
    case (cmd.op)
      OP_LOAD: begin
        mode_r  <= in_ch.mode;
        h_f_r   <= in_ch.altitude_meas;
        vz_f_r  <= in_ch.vspeed_meas;
        va_f_r  <= in_ch.airspeed_meas;
        q_f_r   <= in_ch.pitch_rate_meas;
        az_f_r  <= in_ch.vaccel_meas;
        h_c_r   <= in_ch.altitude_set;
        vz_c_r  <= in_ch.vspeed_set;
        va_c_r  <= in_ch.airspeed_set;
        pe_r    <= in_ch.partner_elevator;
        pt_r    <= in_ch.partner_throttle;
        other_r <= in_ch.other_in_law;
      end
      OP_BAND_OUT: vz_r <= alt_err[OPB_W-1] ? vz_c_r : neg_sat(vz_c_r);
      OP_VZ_CMD:   vz_r <= vz_c_r;
      OP_HOLD_VZ:  vz_r <= to_sig(sat_add(prod_r, hold_int_r));
      OP_ACC_THR:  acc_r <= sat_add(thr_int_r, prod_r);
      OP_ACC_ELEV: acc_r <= sat_add(elev_int_r, prod_r);
      OP_ACC_ADD:  acc_r <= sat_add(acc_r, prod_r);
      OP_THR_OUT:  thr_r <= to_sig(acc_r);
      OP_ELEV_OUT: elev_r <= to_sig(acc_r);
      OP_FINISH: begin
        if (mode_r[1]) begin
          out_elev_r   <= '0;
          out_thr_r    <= '0;
          out_re_r     <= 1'b0;
          out_rt_r     <= 1'b0;
          out_ml_r     <= 1'b0;
          out_status_r <= 1'b1;
        end else begin
          out_elev_r   <= elev_r;
          out_thr_r    <= thr_r;
          out_re_r     <= cfg.monitor_role & (re | other_r);
          out_rt_r     <= cfg.monitor_role & (rt | other_r);
          out_ml_r     <= cfg.monitor_role & re & rt & ~other_r;
          out_status_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.elevator_cmd   = out_elev_r;
  assign out_ch.throttle_cmd   = out_thr_r;
  assign out_ch.relay_elevator = out_re_r;
  assign out_ch.relay_throttle = out_rt_r;
  assign out_ch.law_master     = out_ml_r;
  assign out_ch.status         = out_status_r;

endmodule

>>> hdl/flight_control_pi_law_with_monitor_unit.sv
// ----------------------------------------------------------------------------
// flight_control_pi_law_with_monitor_unit
// PI altitude/speed control law with command/monitor cross-check.
// ----------------------------------------------------------------------------
// One sample item in, one command item out. A sample runs the throttle and
// elevator laws in commanded-vspeed mode or outside the altitude band, adds the
// altitude-hold products before them in altitude hold inside the band, and
// skips the laws for an invalid mode; its result then waits until the previous
// result has left the output register. A single shared 33x33 multiplier builds
// each of the up to thirteen products from two partial products and a
// shift/saturate. A new sample is taken once the sequencer is back in idle,
// even while the previous result still waits in the output register.
module flight_control_pi_law_with_monitor_unit
  import flcpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  flcpi_in_if.sink          in_ch,
  flcpi_out_if.source       out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cfg_t       cfg_r;
  logic [31:0] elev_trim_r, thr_trim_r;
  trim_load_t trim;
  cmd_t       cmd;
  status_t    stat;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       in_ready;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.monitor_role  <= 1'b0;
      cfg_r.sample_period <= SAMPLE_PERIOD_RST;
      cfg_r.airspeed_eq   <= '0;
      cfg_r.altitude_band <= ALTITUDE_BAND_RST;
      cfg_r.mismatch_thr  <= MISMATCH_THR_RST;
      elev_trim_r         <= '0;
      thr_trim_r          <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MONITOR_ROLE:  cfg_r.monitor_role  <= cfg_pwdata[0];
        REG_SAMPLE_PERIOD: cfg_r.sample_period <= cfg_pwdata;
        REG_AIRSPEED_EQ:   cfg_r.airspeed_eq   <= cfg_pwdata;
        REG_ELEVATOR_TRIM: elev_trim_r         <= cfg_pwdata;
        REG_THROTTLE_TRIM: thr_trim_r          <= cfg_pwdata;
        REG_ALTITUDE_BAND: cfg_r.altitude_band <= cfg_pwdata[30:0];
        REG_MISMATCH_THR:  cfg_r.mismatch_thr  <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MONITOR_ROLE:  cfg_prdata = {31'b0, cfg_r.monitor_role};
      REG_SAMPLE_PERIOD: cfg_prdata = cfg_r.sample_period;
      REG_AIRSPEED_EQ:   cfg_prdata = cfg_r.airspeed_eq;
      REG_ELEVATOR_TRIM: cfg_prdata = elev_trim_r;
      REG_THROTTLE_TRIM: cfg_prdata = thr_trim_r;
      REG_ALTITUDE_BAND: cfg_prdata = {1'b0, cfg_r.altitude_band};
      REG_MISMATCH_THR:  cfg_prdata = {1'b0, cfg_r.mismatch_thr};
      default:           cfg_prdata = '0;
    endcase
  end

  // a trim write reloads the matching integrator
  assign trim.elev_load = wr_en && (reg_idx == REG_ELEVATOR_TRIM);
  assign trim.thr_load  = wr_en && (reg_idx == REG_THROTTLE_TRIM);
  assign trim.value     = cfg_pwdata;

  assign in_ch.ready = in_ready;

  flcpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  flcpi_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_r),
    .trim   (trim),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule
